// ----- src/bpsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bpsa_pkg: shared types and constants for the bounded probe slot allocator
// The request and response words, the status and command codes, the default
// sizes and the result record of the in-word free-bit scan.
// ----------------------------------------------------------------------------
package bpsa_pkg;

	// Default table size and probe limit.
	localparam int SLOTS_DEF      = 1024;
	localparam int MAX_PROBES_DEF = 64;

	// Reset value of the slots-in-use register.
	localparam logic [10:0] SLOTS_IN_USE_RESET = 11'd1024;

	// The occupancy bitmap is stored as words of this many slots.
	localparam int WORD_W = 32;
	localparam int OFS_W  = 5;

	// Commands.
	localparam logic CMD_ALLOCATE = 1'b0;
	localparam logic CMD_RELEASE  = 1'b1;

	// Response status codes.
	localparam logic [1:0] STAT_ALLOCATED = 2'd0;
	localparam logic [1:0] STAT_LOST      = 2'd1;
	localparam logic [1:0] STAT_RELEASED  = 2'd2;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic       command;
		logic [9:0] start_index;
		logic [9:0] slot_index;
	} req_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  granted_slot;
		logic [31:0] lost_count;
	} rsp_word_t;

	typedef struct packed {
		logic             found;
		logic [OFS_W-1:0] ofs;
	} scan_t;

endpackage

// ----- src/bpsa_word_scan.sv -----
// ----------------------------------------------------------------------------
// bpsa_word_scan: first free slot within a window of one bitmap word
// Returns the lowest bit position between lo and hi, inclusive, whose
// occupancy bit is clear.
// ----------------------------------------------------------------------------
module bpsa_word_scan (
	input  logic [bpsa_pkg::WORD_W-1:0] data,
	input  logic [bpsa_pkg::OFS_W-1:0]  lo,
	input  logic [bpsa_pkg::OFS_W-1:0]  hi,
	output bpsa_pkg::scan_t             result
);

	// Walk downward so that the lowest free position is the one that stays.
	always_comb begin
		result = '0;
		for (int k = bpsa_pkg::WORD_W - 1; k >= 0; k--) begin
			if ((bpsa_pkg::OFS_W'(k) >= lo) && (bpsa_pkg::OFS_W'(k) <= hi) && !data[k]) begin
				result.found = 1'b1;
				result.ofs   = bpsa_pkg::OFS_W'(k);
			end
		end
	end

endmodule

// ----- src/bounded_probe_slot_allocator_top.sv -----
// ----------------------------------------------------------------------------
// bounded_probe_slot_allocator_top: free slot allocator with bounded probing
// Keeps one occupancy bit per slot in a word-wide synchronous memory, grants
// the first free slot found by a wrapping linear probe and frees slots.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid, req_stall, req): one word per allocate or
//   release, taken at a rising edge with req_valid high and req_stall low.
//   Response channel (rsp_valid, rsp_stall, rsp): exactly one word per
//   request, in request order, taken when rsp_valid is high and rsp_stall is low.
//   Configuration channel (cfg_valid, cfg_ready, cfg_data) writes slots_in_use
//   and is always ready. Write it only while idle; the block does not enforce it.
// Timing
//   The block works on one request at a time. A bad index goes from acceptance
//   straight to the output state. Otherwise each bitmap word visited takes a
//   memory read, then a scan, and a probe of up to MAX_PROBES slots spans at
//   most three words, four when it wraps at the end of the slots in use. A
//   release touches one word. The next request is taken at the edge where the
//   response is first offered.
// Reset and stalls
//   arst_n starts a clearing pass of one bitmap word per cycle over all
//   SLOTS/32 words (32 at the default size), while req_stall stays high. A result
//   waits in the response register while rsp_stall is high; the next request
//   may be worked on meanwhile, and its result is held until the register is
//   free.
// ----------------------------------------------------------------------------
module bounded_probe_slot_allocator_top #(
	parameter int SLOTS      = bpsa_pkg::SLOTS_DEF,
	parameter int MAX_PROBES = bpsa_pkg::MAX_PROBES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bpsa_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bpsa_pkg::rsp_word_t rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [10:0]         cfg_data
);

	localparam int WORDS = (SLOTS + bpsa_pkg::WORD_W - 1) / bpsa_pkg::WORD_W;
	localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int NW    = $clog2(SLOTS + 1);
	localparam int PW    = $clog2(MAX_PROBES + 1);

	// Sequencer states.
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_EV    = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;

	logic [2:0]                  state_q;
	logic [10:0]                 cfg_q;
	logic                        cmd_q;
	logic [NW-1:0]               pos_q;
	logic [PW-1:0]               rem_q;
	logic [1:0]                  status_q;
	logic [9:0]                  grant_q;
	logic [31:0]                 lost_q;
	logic [WAW-1:0]              clr_q;
	logic [bpsa_pkg::WORD_W-1:0] rdata_q;
	logic [bpsa_pkg::WORD_W-1:0] mem [WORDS];
	bpsa_pkg::rsp_word_t         rsp_q;
	logic                        rsp_valid_q;

	logic [NW-1:0]               n_c;
	logic [31:0]                 n32;
	logic [31:0]                 probes_init;
	logic                        req_acc;
	logic                        out_free;
	logic [31:0]                 pos32;
	logic [31:0]                 base32;
	logic [bpsa_pkg::OFS_W-1:0]  boff;
	logic [31:0]                 end_n;
	logic [31:0]                 end_p;
	logic [31:0]                 lim32;
	logic [31:0]                 consumed;
	logic [31:0]                 npos32;
	logic [31:0]                 nrem32;
	logic                        rd_en;
	logic                        wr_en;
	logic [WAW-1:0]              wr_addr;
	logic [bpsa_pkg::WORD_W-1:0] wr_data;
	bpsa_pkg::scan_t             scan;

	// Slots in use, capped at the table size.
	assign n_c = (32'(cfg_q) > SLOTS) ? NW'(SLOTS) : NW'(cfg_q);
	assign n32 = 32'(n_c);
	assign probes_init = (MAX_PROBES > n32) ? n32 : MAX_PROBES;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Probe window inside the current word: from the current slot up to the
	// word end, the last slot in use or the last remaining probe.
	assign pos32  = 32'(pos_q);
	assign base32 = pos32 & ~32'(bpsa_pkg::WORD_W - 1);
	assign boff   = pos32[bpsa_pkg::OFS_W-1:0];
	assign end_n  = n32 - 32'd1 - base32;
	assign end_p  = 32'(boff) + 32'(rem_q) - 32'd1;

	always_comb begin
		lim32 = 32'(bpsa_pkg::WORD_W - 1);
		if (end_n < lim32) begin
			lim32 = end_n;
		end
		if (end_p < lim32) begin
			lim32 = end_p;
		end
	end

	assign consumed = lim32 - 32'(boff) + 32'd1;
	assign npos32   = pos32 + consumed;
	assign nrem32   = 32'(rem_q) - consumed;

	bpsa_word_scan u_scan (
		.data   (rdata_q),
		.lo     (boff),
		.hi     (lim32[bpsa_pkg::OFS_W-1:0]),
		.result (scan)
	);

	// Memory write port: the clearing pass, or the write-back of the scanned
	// word. The write lands before the next read can be issued, since a new
	// read needs at least the return to the read state.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = WAW'(pos32 >> bpsa_pkg::OFS_W);
		wr_data = rdata_q;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_EV: begin
				if (cmd_q == bpsa_pkg::CMD_RELEASE) begin
					wr_en   = 1'b1;
					wr_data = rdata_q & ~(bpsa_pkg::WORD_W'(1) << boff);
				end else if (scan.found) begin
					wr_en   = 1'b1;
					wr_data = rdata_q | (bpsa_pkg::WORD_W'(1) << scan.ofs);
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign rd_en = (state_q == S_RD);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[WAW'(pos32 >> bpsa_pkg::OFS_W)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cfg_q       <= bpsa_pkg::SLOTS_IN_USE_RESET;
			lost_q      <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			// The output state loads the register itself, so it is left out here.
			if (rsp_valid_q && !rsp_stall && state_q != S_PUT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + WAW'(1);
					if (clr_q == WAW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_acc) begin
						cmd_q    <= req.command;
						grant_q  <= '0;
						status_q <= bpsa_pkg::STAT_BAD_INDEX;
						rem_q    <= PW'(probes_init);
						if (req.command == bpsa_pkg::CMD_ALLOCATE) begin
							pos_q <= NW'(req.start_index);
							state_q <= (32'(req.start_index) < n32) ? S_RD : S_PUT;
						end else begin
							pos_q <= NW'(req.slot_index);
							state_q <= (32'(req.slot_index) < n32) ? S_RD : S_PUT;
						end
					end
				end
				S_RD: begin
					state_q <= S_EV;
				end
				S_EV: begin
					if (cmd_q == bpsa_pkg::CMD_RELEASE) begin
						status_q <= bpsa_pkg::STAT_RELEASED;
						state_q  <= S_PUT;
					end else if (scan.found) begin
						status_q <= bpsa_pkg::STAT_ALLOCATED;
						grant_q  <= 10'(base32 + 32'(scan.ofs));
						state_q  <= S_PUT;
					end else if (nrem32 == 32'd0) begin
						status_q <= bpsa_pkg::STAT_LOST;
						if (lost_q != 32'hFFFF_FFFF) begin
							lost_q <= lost_q + 32'd1;
						end
						state_q <= S_PUT;
					end else begin
						// Move on to the next word, wrapping at the slots in use.
						pos_q   <= (npos32 >= n32) ? '0 : NW'(npos32);
						rem_q   <= PW'(nrem32);
						state_q <= S_RD;
					end
				end
				S_PUT: begin
					if (out_free) begin
						rsp_q.status       <= status_q;
						rsp_q.granted_slot <= grant_q;
						rsp_q.lost_count   <= lost_q;
						rsp_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A probe is only issued while probes remain.
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD && cmd_q == bpsa_pkg::CMD_ALLOCATE) |-> rem_q != '0)
		else $error("probe read issued with no probes left");

	// The lost counter only ever steps up by one.
	a_lost_step: assert property (@(posedge clk) disable iff (!arst_n)
		(lost_q != $past(lost_q)) |-> (lost_q == $past(lost_q) + 32'd1))
		else $error("lost counter changed by other than one");

	// A granted slot lies within the slots in use.
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == bpsa_pkg::STAT_ALLOCATED)
			|-> (32'(rsp_q.granted_slot) < n32))
		else $error("granted slot beyond the slots in use");

	// Only an allocation carries a nonzero slot.
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status != bpsa_pkg::STAT_ALLOCATED)
			|-> (rsp_q.granted_slot == '0))
		else $error("slot reported without an allocation");

	// The bitmap is written only by the clearing pass or the scan write-back.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_CLEAR || state_q == S_EV))
		else $error("bitmap written outside clear or scan");

endmodule

// ----- tb/bounded_probe_slot_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_probe_slot_allocator_top_tb: self-checking bench for the allocator
// A short table of directed words covers the field extremes, the empty and
// oversized tables, full tables, release of a free slot and wrapping probes.
// Random phases then run at several table sizes and idling patterns. Every
// accepted request is fed to an in-bench allocation predictor, and every
// response word is compared field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module bounded_probe_slot_allocator_top_tb;

	localparam int CLK_HALF    = 4;
	localparam int DRAIN_PAUSE = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int DIR_ROWS    = 25;
	localparam int PHASES      = 11;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_e;

	typedef enum logic {
		ROW_REQ,
		ROW_CFG
	} row_kind_e;

	// One row of the directed table. A config row uses only size; a request
	// row carries a typed expectation only when fixed is set.
	typedef struct packed {
		row_kind_e   kind;
		logic [10:0] size;
		logic        command;
		logic [9:0]  start_index;
		logic [9:0]  slot_index;
		logic        fixed;
		logic [1:0]  status;
		logic [9:0]  granted_slot;
		logic [31:0] lost_count;
	} dir_row_t;

	typedef struct packed {
		logic [10:0] size;
		logic [10:0] items;
		idle_mode_e  mode;
		logic        hold;
	} phase_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	bpsa_pkg::req_word_t req = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	bpsa_pkg::rsp_word_t rsp;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [10:0]         cfg_data = '0;

	// Side band that travels with each request word: a typed expectation.
	logic                req_fixed = 1'b0;
	bpsa_pkg::rsp_word_t req_fixed_rsp = '0;

	// Predictor state: occupancy, lost tally and the slots-in-use register.
	logic        slot_taken [bpsa_pkg::SLOTS_DEF];
	logic [31:0] lost_tally = '0;
	logic [10:0] table_size = bpsa_pkg::SLOTS_IN_USE_RESET;

	bpsa_pkg::rsp_word_t expected_rsps [$];
	idle_mode_e  idle_mode = IDLE_NONE;
	int          hold_ticket = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          errors = 0;
	int          n_requests = 0;
	int          n_granted = 0;
	int          n_lost = 0;
	int          n_released = 0;
	int          n_bad = 0;
	int          n_sizes = 0;

	dir_row_t dir_table [DIR_ROWS] = '{
		// After reset: lowest and highest start both grant directly.
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd0, 10'd0, 1'b1,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd1023, 10'd1023, 1'b1,
			bpsa_pkg::STAT_ALLOCATED, 10'd1023, 32'd0},
		// Top slot taken, probe wraps past slot 0 as well.
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd1023, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_RELEASE, 10'd1023, 10'd1023, 1'b1,
			bpsa_pkg::STAT_RELEASED, 10'd0, 32'd0},
		// Releasing a slot that is already free still answers released.
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_RELEASE, 10'd0, 10'd1023, 1'b1,
			bpsa_pkg::STAT_RELEASED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_RELEASE, 10'd1023, 10'd0, 1'b1,
			bpsa_pkg::STAT_RELEASED, 10'd0, 32'd0},
		// Empty table: everything is out of range.
		'{ROW_CFG, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd0, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd0, 10'd0, 1'b1,
			bpsa_pkg::STAT_BAD_INDEX, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_RELEASE, 10'd0, 10'd0, 1'b1,
			bpsa_pkg::STAT_BAD_INDEX, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd1023, 10'd1023, 1'b1,
			bpsa_pkg::STAT_BAD_INDEX, 10'd0, 32'd0},
		// Oversized register value behaves as the full table.
		'{ROW_CFG, 11'd2047, bpsa_pkg::CMD_ALLOCATE, 10'd0, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd1023, 10'd0, 1'b1,
			bpsa_pkg::STAT_ALLOCATED, 10'd1023, 32'd0},
		// A single slot: grant, then a lost request, then out of range.
		'{ROW_CFG, 11'd1, bpsa_pkg::CMD_ALLOCATE, 10'd0, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd0, 10'd0, 1'b1,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd0, 10'd0, 1'b1,
			bpsa_pkg::STAT_LOST, 10'd0, 32'd1},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd1, 10'd0, 1'b1,
			bpsa_pkg::STAT_BAD_INDEX, 10'd0, 32'd1},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_RELEASE, 10'd0, 10'd1, 1'b1,
			bpsa_pkg::STAT_BAD_INDEX, 10'd0, 32'd1},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_RELEASE, 10'd0, 10'd0, 1'b1,
			bpsa_pkg::STAT_RELEASED, 10'd0, 32'd1},
		// Three slots: wrap at the end of the slots in use, then a full table.
		'{ROW_CFG, 11'd3, bpsa_pkg::CMD_ALLOCATE, 10'd0, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd2, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd2, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd2, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_CFG, 11'd1024, bpsa_pkg::CMD_ALLOCATE, 10'd0, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_ALLOCATE, 10'd1, 10'd0, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0},
		'{ROW_REQ, 11'd0, bpsa_pkg::CMD_RELEASE, 10'd0, 10'd512, 1'b0,
			bpsa_pkg::STAT_ALLOCATED, 10'd0, 32'd0}
	};

	// Sizes revisit earlier ones on purpose, so that slots left taken above
	// a smaller table come back into range later.
	phase_t phase_plan [PHASES] = '{
		'{11'd1024, 11'd100, IDLE_NONE, 1'b0},
		'{11'd100,  11'd150, IDLE_SEND, 1'b0},
		'{11'd65,   11'd100, IDLE_RECV, 1'b0},
		'{11'd64,   11'd100, IDLE_BOTH, 1'b0},
		'{11'd2,    11'd60,  IDLE_NONE, 1'b0},
		'{11'd0,    11'd30,  IDLE_BOTH, 1'b0},
		'{11'd2047, 11'd120, IDLE_RECV, 1'b0},
		'{11'd5,    11'd60,  IDLE_SEND, 1'b0},
		'{11'd1000, 11'd100, IDLE_BOTH, 1'b0},
		'{11'd33,   11'd100, IDLE_NONE, 1'b0},
		'{11'd100,  11'd80,  IDLE_NONE, 1'b1}
	};

	bounded_probe_slot_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	initial begin
		for (int i = 0; i < bpsa_pkg::SLOTS_DEF; i++) slot_taken[i] = 1'b0;
	end

	// Allocation predictor: bounded wrapping probe over the occupancy bits.
	function automatic bpsa_pkg::rsp_word_t predict_slot_op(
			input bpsa_pkg::req_word_t w);
		int unsigned         n;
		int unsigned         probes;
		int unsigned         pos;
		logic                found;
		bpsa_pkg::rsp_word_t r;
		n = (32'(table_size) > bpsa_pkg::SLOTS_DEF) ? bpsa_pkg::SLOTS_DEF
			: 32'(table_size);
		r = '0;
		r.status = bpsa_pkg::STAT_BAD_INDEX;
		found = 1'b0;
		if (w.command == bpsa_pkg::CMD_ALLOCATE) begin
			if (32'(w.start_index) < n) begin
				probes = (bpsa_pkg::MAX_PROBES_DEF > n) ? n : bpsa_pkg::MAX_PROBES_DEF;
				pos = 32'(w.start_index);
				for (int unsigned k = 0; k < probes && !found; k++) begin
					if (!slot_taken[pos]) begin
						slot_taken[pos] = 1'b1;
						r.granted_slot = pos[9:0];
						found = 1'b1;
					end else begin
						pos++;
						if (pos >= n) pos = 0;
					end
				end
				if (found) begin
					r.status = bpsa_pkg::STAT_ALLOCATED;
				end else begin
					r.status = bpsa_pkg::STAT_LOST;
					if (lost_tally != 32'hFFFF_FFFF) lost_tally++;
				end
			end
		end else if (32'(w.slot_index) < n) begin
			slot_taken[w.slot_index] = 1'b0;
			r.status = bpsa_pkg::STAT_RELEASED;
		end
		r.lost_count = lost_tally;
		return r;
	endfunction

	function automatic logic rest_now(input logic sender_side);
		int unsigned pct;
		case (idle_mode)
			IDLE_SEND: pct = sender_side ? 60 : 0;
			IDLE_RECV: pct = sender_side ? 0 : 60;
			IDLE_BOTH: pct = 11;
			default:   pct = 0;
		endcase
		return $urandom_range(99) < pct;
	endfunction

	// Mostly in-range allocates and releases, with a little full-range noise.
	function automatic bpsa_pkg::req_word_t random_request(input int unsigned n);
		bpsa_pkg::req_word_t w;
		int unsigned         pick;
		w.command = 1'($urandom_range(1));
		w.start_index = 10'($urandom_range(1023));
		w.slot_index = 10'($urandom_range(1023));
		pick = $urandom_range(99);
		if (pick >= 4 && n > 0) begin
			if (pick < 62) begin
				w.command = bpsa_pkg::CMD_ALLOCATE;
				w.start_index = 10'($urandom_range(n - 1));
			end else begin
				w.command = bpsa_pkg::CMD_RELEASE;
				w.slot_index = 10'($urandom_range(n - 1));
			end
		end
		return w;
	endfunction

	// Receiver: random stalls, or one long hold-off when the main flow asks.
	always @(negedge clk) begin
		if (hold_ticket != hold_seen) begin
			hold_seen = hold_ticket;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= rest_now(1'b0);
		end
	end

	// Monitor: predict on every accepted request word, check every response.
	always @(posedge clk) begin
		bpsa_pkg::rsp_word_t pred;
		bpsa_pkg::rsp_word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) table_size = cfg_data;
			if (req_valid && !req_stall) begin
				pred = predict_slot_op(req);
				expected_rsps.push_back(req_fixed ? req_fixed_rsp : pred);
				n_requests++;
				case (pred.status)
					bpsa_pkg::STAT_ALLOCATED: n_granted++;
					bpsa_pkg::STAT_LOST:      n_lost++;
					bpsa_pkg::STAT_RELEASED:  n_released++;
					default:                  n_bad++;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t ns: response word with nothing expected, got %h",
						$time, rsp);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp.status !== want.status) begin
						$display("%0t ns: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp.status);
						errors++;
					end
					if (rsp.granted_slot !== want.granted_slot) begin
						$display("%0t ns: granted_slot mismatch, expected %0d, got %0d",
							$time, want.granted_slot, rsp.granted_slot);
						errors++;
					end
					if (rsp.lost_count !== want.lost_count) begin
						$display("%0t ns: lost_count mismatch, expected %0d, got %0d",
							$time, want.lost_count, rsp.lost_count);
						errors++;
					end
				end
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with req_valid still high, so the caller sets it exactly once next.
	task automatic offer_request(input bpsa_pkg::req_word_t w, input logic fixed,
			input bpsa_pkg::rsp_word_t want);
		while (rest_now(1'b1)) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		req_fixed <= fixed;
		req_fixed_rsp <= want;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop sending and wait until every expected response word is back.
	task automatic settle_idle();
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic write_size(input logic [10:0] size);
		cfg_valid <= 1'b1;
		cfg_data <= size;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_sizes++;
	endtask

	initial begin
		bpsa_pkg::req_word_t w;
		bpsa_pkg::rsp_word_t want;
		int unsigned         n;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_table[i].kind == ROW_CFG) begin
				settle_idle();
				write_size(dir_table[i].size);
			end else begin
				w.command = dir_table[i].command;
				w.start_index = dir_table[i].start_index;
				w.slot_index = dir_table[i].slot_index;
				want.status = dir_table[i].status;
				want.granted_slot = dir_table[i].granted_slot;
				want.lost_count = dir_table[i].lost_count;
				offer_request(w, dir_table[i].fixed, want);
			end
		end

		// Random phases, each at its own table size and idling pattern.
		for (int p = 0; p < PHASES; p++) begin
			settle_idle();
			write_size(phase_plan[p].size);
			idle_mode = phase_plan[p].mode;
			// The long hold-off backs the block up while words keep coming.
			if (phase_plan[p].hold) hold_ticket++;
			n = (32'(phase_plan[p].size) > bpsa_pkg::SLOTS_DEF) ? bpsa_pkg::SLOTS_DEF
				: 32'(phase_plan[p].size);
			for (int i = 0; i < 32'(phase_plan[p].items); i++) begin
				offer_request(random_request(n), 1'b0, '0);
			end
		end

		idle_mode = IDLE_NONE;
		settle_idle();
		repeat (DRAIN_PAUSE) @(posedge clk);
		if (expected_rsps.size() != 0) begin
			$display("%0t ns: %0d response words never arrived",
				$time, expected_rsps.size());
			errors++;
		end

		$display("Covered %0d requests over %0d register writes: %0d granted, %0d lost,",
			n_requests, n_sizes, n_granted, n_lost);
		$display("%0d released and %0d out of range, with %0d mismatches.",
			n_released, n_bad, errors);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("%0t ns: timeout", $time);
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
src/bpsa_pkg.sv
src/bpsa_word_scan.sv
src/bounded_probe_slot_allocator_top.sv
tb/bounded_probe_slot_allocator_top_tb.sv
